FILE: hdl/i2cm_pkg.sv
`timescale 1ns / 1ps
package i2cm_pkg;

  // Command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Bus phase codes
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_WAIT = 4'd1;
  localparam logic [3:0] PH_START_HOLD = 4'd2;
  localparam logic [3:0] PH_STOP_WAIT  = 4'd3;
  localparam logic [3:0] PH_STOP_LONG  = 4'd4;
  localparam logic [3:0] PH_STOP_SHORT = 4'd5;
  localparam logic [3:0] PH_BIT_LOW    = 4'd6;
  localparam logic [3:0] PH_BIT_RISE   = 4'd7;
  localparam logic [3:0] PH_BIT_HIGH   = 4'd8;
  localparam logic [3:0] PH_TAIL       = 4'd9;

  // Configuration register indexes and reset values
  localparam logic REG_LONG_WAIT  = 1'b0;
  localparam logic REG_SHORT_WAIT = 1'b1;
  localparam logic [7:0] LONG_WAIT_RESET  = 8'd5;
  localparam logic [7:0] SHORT_WAIT_RESET = 8'd4;

  localparam logic [7:0] RELEASED_BYTE = 8'hFF;
  localparam logic [3:0] DATA_BITS     = 4'd8;
  localparam logic [3:0] ACK_DONE      = 4'd9;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       scl_in;
    logic       sda_in;
  } i2cm_item_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] tick_count;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic       last_ack;
    logic [7:0] read_hold;
    logic       op_is_read;
    logic       ack_choice;
    logic       scl_parked;
  } i2cm_state_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
  } i2cm_result_t;

endpackage

FILE: hdl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// I2C master byte engine. Each input word is one bus timing tick carrying a
// command (in tuser) and the sampled SCL/SDA pin levels; each accepted word
// produces exactly one output word with the SCL/SDA pull-low controls, busy
// and done flags, the last read byte and the last ACK seen. Commands (start,
// stop, write byte, read byte) are taken only while idle and are ignored
// otherwise. A new word is accepted every clock cycle while the output is not
// stalled; the word sits in the input register while the bus-phase step runs,
// and the step's result lands in the output register. The output register
// and the input register decouple the two sides, so the input keeps flowing
// while a result waits, stalling only once both registers are full. The
// wait lengths are written through the cfg port (index 0 long wait, index 1
// short wait); the user must write them only while idle, which the block itself
// does not enforce. A wait of zero behaves as one tick.
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // data_byte[7:0], ack_to_send[8], scl_in[9], sda_in[10], zeros
  input  logic [2:0]  s_tuser,  // command[2:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // scl_drive_low[0], sda_drive_low[1], busy_res[2],
                                // done_res[3], read_data[11:4], ack_received[12], zeros
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic         in_valid;
  i2cm_item_t   in_item;
  logic         out_valid;
  i2cm_result_t out_result;
  i2cm_state_t  state;
  i2cm_state_t  state_next;
  i2cm_result_t step_result;
  logic [7:0]   long_wait_ticks;
  logic [7:0]   short_wait_ticks;
  logic         advance;

  // Step the held word when the output register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command     <= s_tuser;
      in_item.data_byte   <= s_tdata[7:0];
      in_item.ack_to_send <= s_tdata[8];
      in_item.scl_in      <= s_tdata[9];
      in_item.sda_in      <= s_tdata[10];
    end
  end

  // Wait-length registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_wait_ticks  <= LONG_WAIT_RESET;
      short_wait_ticks <= SHORT_WAIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_WAIT:  long_wait_ticks  <= cfg_data;
        REG_SHORT_WAIT: short_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cm_step u_step (
    .state            (state),
    .item             (in_item),
    .long_wait_ticks  (long_wait_ticks),
    .short_wait_ticks (short_wait_ticks),
    .state_next       (state_next),
    .result           (step_result)
  );

  // Bus state advances once per stepped word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_IDLE;
      state.tick_count <= '0;
      state.bit_count  <= '0;
      state.shift_reg  <= RELEASED_BYTE;
      state.last_ack   <= 1'b0;
      state.read_hold  <= '0;
      state.op_is_read <= 1'b0;
      state.ack_choice <= 1'b0;
      state.scl_parked <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000,
                     out_result.ack_received,
                     out_result.read_data,
                     out_result.done_res,
                     out_result.busy_res,
                     out_result.sda_drive_low,
                     out_result.scl_drive_low};

endmodule

FILE: hdl/i2cm_step.sv
`timescale 1ns / 1ps
module i2cm_step import i2cm_pkg::*; (
  input  i2cm_state_t  state,
  input  i2cm_item_t   item,
  input  logic [7:0]   long_wait_ticks,
  input  logic [7:0]   short_wait_ticks,
  output i2cm_state_t  state_next,
  output i2cm_result_t result
);

  logic [8:0] tick_inc;
  logic       long_over;
  logic       short_over;
  logic       done;
  logic [7:0] shifted;

  // Tick counter compare, shared by all waits
  assign tick_inc   = {1'b0, state.tick_count} + 9'd1;
  assign long_over  = tick_inc >= {1'b0, long_wait_ticks};
  assign short_over = tick_inc >= {1'b0, short_wait_ticks};
  assign shifted    = {state.shift_reg[6:0], item.sda_in};

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state.phase)
      PH_START_WAIT: begin
        if (item.scl_in) begin
          state_next.phase      = PH_START_HOLD;
          state_next.tick_count = '0;
        end
      end
      PH_START_HOLD: begin
        if (long_over) begin
          state_next.tick_count = '0;
          state_next.phase      = PH_IDLE;
          state_next.scl_parked = 1'b1;
          done                  = 1'b1;
        end else begin
          state_next.tick_count = tick_inc[7:0];
        end
      end
      PH_STOP_WAIT: begin
        if (item.scl_in) begin
          state_next.phase      = PH_STOP_LONG;
          state_next.tick_count = '0;
        end
      end
      PH_STOP_LONG: begin
        if (long_over) begin
          state_next.tick_count = '0;
          state_next.phase      = PH_STOP_SHORT;
        end else begin
          state_next.tick_count = tick_inc[7:0];
        end
      end
      PH_STOP_SHORT: begin
        if (short_over) begin
          state_next.tick_count = '0;
          state_next.phase      = PH_IDLE;
          state_next.scl_parked = 1'b0;
          done                  = 1'b1;
        end else begin
          state_next.tick_count = tick_inc[7:0];
        end
      end
      PH_BIT_LOW: begin
        if (long_over) begin
          state_next.tick_count = '0;
          state_next.phase      = PH_BIT_RISE;
        end else begin
          state_next.tick_count = tick_inc[7:0];
        end
      end
      PH_BIT_RISE: begin
        // wait out clock stretching
        if (item.scl_in) begin
          state_next.phase      = PH_BIT_HIGH;
          state_next.tick_count = '0;
        end
      end
      PH_BIT_HIGH: begin
        if (short_over) begin
          state_next.tick_count = '0;
          if (state.bit_count >= DATA_BITS) begin
            // ack bit sampled
            if (!state.op_is_read) state_next.last_ack = ~item.sda_in;
            state_next.bit_count = ACK_DONE;
            state_next.phase     = PH_TAIL;
            state_next.shift_reg = RELEASED_BYTE;
          end else begin
            state_next.bit_count = state.bit_count + 4'd1;
            if (state.bit_count == DATA_BITS - 4'd1) begin
              if (state.op_is_read) state_next.read_hold = shifted;
              state_next.phase     = PH_TAIL;
              state_next.shift_reg = RELEASED_BYTE;
            end else begin
              state_next.shift_reg = shifted;
              state_next.phase     = PH_BIT_LOW;
            end
          end
        end else begin
          state_next.tick_count = tick_inc[7:0];
        end
      end
      PH_TAIL: begin
        if (long_over) begin
          state_next.tick_count = '0;
          if (state.bit_count == DATA_BITS) begin
            state_next.shift_reg = (state.op_is_read && state.ack_choice) ? 8'h00
                                                                          : RELEASED_BYTE;
            state_next.phase     = PH_BIT_LOW;
          end else begin
            state_next.bit_count  = '0;
            state_next.shift_reg  = RELEASED_BYTE;
            state_next.phase      = PH_IDLE;
            state_next.scl_parked = 1'b1;
            done                  = 1'b1;
          end
        end else begin
          state_next.tick_count = tick_inc[7:0];
        end
      end
      default: begin
        // idle, and any stray code: take a command
        state_next.phase      = PH_IDLE;
        state_next.tick_count = '0;
        case (item.command)
          CMD_START: state_next.phase = PH_START_WAIT;
          CMD_STOP:  state_next.phase = PH_STOP_WAIT;
          CMD_WRITE, CMD_READ: begin
            state_next.op_is_read = item.command == CMD_READ;
            state_next.ack_choice = item.ack_to_send;
            state_next.shift_reg  = (item.command == CMD_READ) ? RELEASED_BYTE
                                                               : item.data_byte;
            state_next.bit_count  = '0;
            state_next.phase      = PH_BIT_LOW;
          end
          default: ;
        endcase
      end
    endcase
  end

  // Pin drive follows the updated phase
  always_comb begin
    result.scl_drive_low = 1'b0;
    result.sda_drive_low = 1'b0;
    case (state_next.phase)
      PH_IDLE: result.scl_drive_low = state_next.scl_parked;
      PH_START_HOLD, PH_STOP_WAIT, PH_STOP_LONG: result.sda_drive_low = 1'b1;
      PH_BIT_LOW: begin
        result.scl_drive_low = 1'b1;
        result.sda_drive_low = ~state_next.shift_reg[7];
      end
      PH_BIT_RISE, PH_BIT_HIGH: result.sda_drive_low = ~state_next.shift_reg[7];
      PH_TAIL: result.scl_drive_low = 1'b1;
      default: ;
    endcase
    result.busy_res     = state_next.phase != PH_IDLE;
    result.done_res     = done;
    result.read_data    = state_next.read_hold;
    result.ack_received = state_next.last_ack;
  end

endmodule

FILE: test/i2cm_bus_checker.sv
`timescale 1ns / 1ps
module i2cm_bus_checker import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], ack_to_send[8], scl_in[9], sda_in[10], zeros
  input  logic [2:0]  s_tuser,   // command[2:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // scl_drive_low[0], sda_drive_low[1], busy_res[2],
                                 // done_res[3], read_data[11:4], ack_received[12], zeros
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outputs_due,
  output logic        engine_idle
);

  logic [7:0]   long_wait;
  logic [7:0]   short_wait;
  i2cm_state_t  bus;
  i2cm_result_t bus_outputs_q[$];
  i2cm_result_t want;
  i2cm_item_t   tick_in;

  // Count one tick of a wait; true once the wait is over (zero acts as one).
  function automatic logic wait_elapsed(input logic [7:0] len);
    logic [8:0] next_count;
    next_count = {1'b0, bus.tick_count} + 9'd1;
    if (next_count >= {1'b0, len}) begin
      bus.tick_count = '0;
      return 1'b1;
    end
    bus.tick_count = next_count[7:0];
    return 1'b0;
  endfunction

  // Advance the bus engine by one tick and return the pin drives and status.
  function automatic i2cm_result_t advance_engine(input i2cm_item_t w);
    logic         finished;
    i2cm_result_t res;
    finished = 1'b0;
    res = '0;
    case (bus.phase)
      PH_START_WAIT: if (w.scl_in) begin
        bus.phase = PH_START_HOLD;
        bus.tick_count = '0;
      end
      PH_START_HOLD: if (wait_elapsed(long_wait)) begin
        bus.phase = PH_IDLE;
        bus.scl_parked = 1'b1;
        finished = 1'b1;
      end
      PH_STOP_WAIT: if (w.scl_in) begin
        bus.phase = PH_STOP_LONG;
        bus.tick_count = '0;
      end
      PH_STOP_LONG: if (wait_elapsed(long_wait)) bus.phase = PH_STOP_SHORT;
      PH_STOP_SHORT: if (wait_elapsed(short_wait)) begin
        bus.phase = PH_IDLE;
        bus.scl_parked = 1'b0;
        finished = 1'b1;
      end
      PH_BIT_LOW: if (wait_elapsed(long_wait)) bus.phase = PH_BIT_RISE;
      PH_BIT_RISE: if (w.scl_in) begin
        bus.phase = PH_BIT_HIGH;
        bus.tick_count = '0;
      end
      PH_BIT_HIGH: if (wait_elapsed(short_wait)) begin
        bus.shift_reg = {bus.shift_reg[6:0], w.sda_in};
        if (bus.bit_count >= DATA_BITS) begin
          // ack bit: only a write records the slave's answer
          if (!bus.op_is_read) bus.last_ack = ~w.sda_in;
          bus.bit_count = ACK_DONE;
          bus.phase = PH_TAIL;
          bus.shift_reg = RELEASED_BYTE;
        end else begin
          bus.bit_count = bus.bit_count + 4'd1;
          if (bus.bit_count >= DATA_BITS) begin
            if (bus.op_is_read) bus.read_hold = bus.shift_reg;
            bus.phase = PH_TAIL;
            bus.shift_reg = RELEASED_BYTE;
          end else begin
            bus.phase = PH_BIT_LOW;
          end
        end
      end
      PH_TAIL: if (wait_elapsed(long_wait)) begin
        if (bus.bit_count == DATA_BITS) begin
          bus.shift_reg = (bus.op_is_read && bus.ack_choice) ? 8'h00 : RELEASED_BYTE;
          bus.phase = PH_BIT_LOW;
        end else begin
          bus.bit_count = '0;
          bus.shift_reg = RELEASED_BYTE;
          bus.phase = PH_IDLE;
          bus.scl_parked = 1'b1;
          finished = 1'b1;
        end
      end
      default: begin
        bus.phase = PH_IDLE;
        bus.tick_count = '0;
        case (w.command)
          CMD_START: bus.phase = PH_START_WAIT;
          CMD_STOP:  bus.phase = PH_STOP_WAIT;
          CMD_WRITE, CMD_READ: begin
            bus.op_is_read = (w.command == CMD_READ);
            bus.ack_choice = w.ack_to_send;
            bus.shift_reg = bus.op_is_read ? RELEASED_BYTE : w.data_byte;
            bus.bit_count = '0;
            bus.phase = PH_BIT_LOW;
          end
          default: ;
        endcase
      end
    endcase

    case (bus.phase)
      PH_IDLE: res.scl_drive_low = bus.scl_parked;
      PH_START_HOLD, PH_STOP_WAIT, PH_STOP_LONG: res.sda_drive_low = 1'b1;
      PH_BIT_LOW: begin
        res.scl_drive_low = 1'b1;
        res.sda_drive_low = ~bus.shift_reg[7];
      end
      PH_BIT_RISE, PH_BIT_HIGH: res.sda_drive_low = ~bus.shift_reg[7];
      PH_TAIL: res.scl_drive_low = 1'b1;
      default: ;
    endcase
    res.busy_res     = (bus.phase != PH_IDLE);
    res.done_res     = finished;
    res.read_data    = bus.read_hold;
    res.ack_received = bus.last_ack;
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
    if (exp_val !== got_val) begin
      mismatches = mismatches + 1;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      long_wait  = LONG_WAIT_RESET;
      short_wait = SHORT_WAIT_RESET;
      bus = '0;
      bus.phase = PH_IDLE;
      bus.shift_reg = RELEASED_BYTE;
      bus_outputs_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_LONG_WAIT) long_wait = cfg_data;
        else short_wait = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        if (bus_outputs_q.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: result word %h arrived with nothing expected", $time, m_tdata);
        end else begin
          want = bus_outputs_q.pop_front();
          compare_field("scl_drive_low", 8'(want.scl_drive_low), 8'(m_tdata[0]));
          compare_field("sda_drive_low", 8'(want.sda_drive_low), 8'(m_tdata[1]));
          compare_field("busy_res", 8'(want.busy_res), 8'(m_tdata[2]));
          compare_field("done_res", 8'(want.done_res), 8'(m_tdata[3]));
          compare_field("read_data", want.read_data, m_tdata[11:4]);
          compare_field("ack_received", 8'(want.ack_received), 8'(m_tdata[12]));
        end
      end
      if (s_tvalid && s_tready) begin
        tick_in.command     = s_tuser;
        tick_in.data_byte   = s_tdata[7:0];
        tick_in.ack_to_send = s_tdata[8];
        tick_in.scl_in      = s_tdata[9];
        tick_in.sda_in      = s_tdata[10];
        bus_outputs_q.push_back(advance_engine(tick_in));
      end
    end
    outputs_due <= bus_outputs_q.size();
    engine_idle <= (bus.phase == PH_IDLE);
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import i2cm_pkg::*;

  // Command codes the engine has no meaning for; it must treat them as a bare tick.
  localparam logic [2:0] CMD_RSVD_5 = 3'd5;
  localparam logic [2:0] CMD_RSVD_6 = 3'd6;
  localparam logic [2:0] CMD_RSVD_7 = 3'd7;

  localparam int RESULT_LATENCY = 2;     // input register plus output register
  localparam int HOLD_CYCLES    = 48;    // long receiver back-pressure stretch
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no word moving on either side

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;       // data_byte[7:0], ack_to_send[8], scl_in[9], sda_in[10], zeros
  logic [2:0]  s_tuser = CMD_TICK; // command[2:0]

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;            // scl_drive_low[0], sda_drive_low[1], busy_res[2],
                                   // done_res[3], read_data[11:4], ack_received[12], zeros

  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_LONG_WAIT;
  logic [7:0]  cfg_data = '0;

  int          mismatches;
  int          outputs_due;
  logic        engine_idle;

  int          tx_idle_pct = 0;     // sender gap chance, percent per word
  int          rx_idle_pct = 0;     // receiver stall chance, percent per cycle
  logic        rx_hold_req = 1'b0;
  logic        rx_hold_taken = 1'b0;
  int          rx_hold_left = 0;
  int          quiet_cycles = 0;
  int          stretch_left = 0;    // remaining ticks of a slave holding SCL low
  i2cm_item_t  cmd_plan[$];         // upcoming commands of a well-formed transfer

  i2c_master_byte_engine DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  i2cm_bus_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outputs_due(outputs_due), .engine_idle(engine_idle)
  );

  always #2 clk = ~clk;

  // Receiver: stall at random, and once on request hold off for a long stretch
  // so the engine's registers fill and its input backs up.
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req && !rx_hold_taken) begin
      m_tready <= 1'b0;
      rx_hold_taken <= 1'b1;
      rx_hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic i2cm_item_t word_of(input logic [2:0] cmd, input logic [7:0] data,
                                         input logic ack, input logic scl, input logic sda);
    i2cm_item_t w;
    w.command     = cmd;
    w.data_byte   = data;
    w.ack_to_send = ack;
    w.scl_in      = scl;
    w.sda_in      = sda;
    return w;
  endfunction

  // Offer one tick word after an optional random gap; return on the edge that takes it.
  task automatic send_word(input i2cm_item_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.command;
    s_tdata  <= {5'b0, w.sda_in, w.scl_in, w.ack_to_send, w.data_byte};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and hold until every predicted word has come back.
  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outputs_due != 0);
  endtask

  // Feed bare ticks with SCL released until the engine finishes its command.
  task automatic settle_engine();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (!engine_idle) begin
      send_word(word_of(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'b1, 1'($urandom_range(0, 1))));
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Change both wait lengths with the engine idle and the pipeline empty.
  task automatic reconfigure(input logic [7:0] long_ticks, input logic [7:0] short_ticks);
    settle_engine();
    wait_results();
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LONG_WAIT;
    cfg_data  <= long_ticks;
    @(posedge clk);
    cfg_index <= REG_SHORT_WAIT;
    cfg_data  <= short_ticks;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Queue one bus transfer: start, address byte, a few data bytes, usually a stop.
  // Reads ACK every byte but the last, which gets a NACK.
  task automatic plan_transfer();
    int   n_bytes;
    logic reading;
    n_bytes = $urandom_range(1, 3);
    reading = 1'($urandom_range(0, 1));
    cmd_plan.push_back(word_of(CMD_START, 8'h00, 1'b0, 1'b1, 1'b1));
    cmd_plan.push_back(word_of(CMD_WRITE, {7'($urandom_range(0, 127)), reading},
                               1'b0, 1'b1, 1'b1));
    for (int k = 0; k < n_bytes; k++)
      cmd_plan.push_back(word_of(reading ? CMD_READ : CMD_WRITE, 8'($urandom_range(0, 255)),
                                 k != n_bytes - 1, 1'b1, 1'b1));
    // leave the stop out now and then, so the next start is a repeated start
    if ($urandom_range(0, 3) != 0)
      cmd_plan.push_back(word_of(CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1));
  endtask

  // Random ticks: mostly planned transfers issued while the engine is idle,
  // some stray commands (reserved codes and commands while busy), random
  // SDA samples and short clock-stretch bursts on SCL.
  task automatic run_random(input int n_items);
    i2cm_item_t w;
    i2cm_item_t step;
    logic [2:0] prev_cmd;
    prev_cmd = CMD_TICK;
    for (int i = 0; i < n_items; i++) begin
      w = word_of(CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 19) == 0) begin
        w.command = 3'($urandom_range(0, 7));
      end else if (engine_idle && prev_cmd == CMD_TICK && $urandom_range(0, 2) == 0) begin
        if (cmd_plan.size() == 0) plan_transfer();
        step = cmd_plan.pop_front();
        w.command     = step.command;
        w.data_byte   = step.data_byte;
        w.ack_to_send = step.ack_to_send;
      end
      if (stretch_left > 0) begin
        w.scl_in = 1'b0;
        stretch_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        w.scl_in = 1'b0;
        stretch_left = $urandom_range(0, 5);
      end
      send_word(w);
      prev_cmd = w.command;
    end
  endtask

  // Short hand-built walk with long wait 1 and short wait 0: field extremes,
  // reserved codes, a stop and a start with clock stretching, commands while
  // busy, and the opening bits of a write issued after the start.
  task automatic run_directed();
    send_word(word_of(CMD_TICK,   8'hFF, 1'b1, 1'b0, 1'b0));
    send_word(word_of(CMD_RSVD_5, 8'h00, 1'b0, 1'b1, 1'b1));
    send_word(word_of(CMD_RSVD_6, 8'hAA, 1'b1, 1'b0, 1'b1));
    send_word(word_of(CMD_RSVD_7, 8'h55, 1'b0, 1'b1, 1'b0));
    // stop from idle, slave stretching SCL for one tick
    send_word(word_of(CMD_STOP,   8'h00, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CMD_TICK,   8'h00, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CMD_TICK,   8'h00, 1'b0, 1'b1, 1'b1));
    send_word(word_of(CMD_TICK,   8'h00, 1'b0, 1'b1, 1'b1));
    send_word(word_of(CMD_TICK,   8'h00, 1'b0, 1'b1, 1'b1));
    // start, then a read offered while the start hold runs
    send_word(word_of(CMD_START,  8'hFF, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CMD_TICK,   8'h00, 1'b0, 1'b0, 1'b1));
    send_word(word_of(CMD_TICK,   8'h00, 1'b0, 1'b1, 1'b1));
    send_word(word_of(CMD_READ,   8'h00, 1'b1, 1'b1, 1'b0));
    // write of all zeros, stretched on the first rise, another write ignored
    send_word(word_of(CMD_WRITE,  8'h00, 1'b1, 1'b1, 1'b0));
    send_word(word_of(CMD_TICK,   8'hFF, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK,   8'hFF, 1'b0, 1'b0, 1'b0));
    send_word(word_of(CMD_TICK,   8'hFF, 1'b0, 1'b1, 1'b0));
    send_word(word_of(CMD_TICK,   8'hFF, 1'b0, 1'b1, 1'b1));
    send_word(word_of(CMD_WRITE,  8'hFF, 1'b1, 1'b1, 1'b1));
    send_word(word_of(CMD_STOP,   8'h00, 1'b0, 1'b1, 1'b0));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero short wait must behave as one tick
    reconfigure(8'd1, 8'd0);
    run_directed();

    // sender idles lightly, receiver heavily
    tx_idle_pct = 12;
    rx_idle_pct <= 72;
    reconfigure(8'd1, 8'd1);
    run_random(380);
    reconfigure(8'd255, 8'd1);
    run_random(260);

    // swap: sender gappy, receiver mostly ready
    tx_idle_pct = 72;
    rx_idle_pct <= 12;
    reconfigure(8'd1, 8'd255);
    run_random(260);
    reconfigure(8'd2, 8'd1);
    run_random(200);
    // pause the sender until every result is back, then carry on
    wait_results();
    run_random(200);

    // full rate both ways, zero long wait, and one long receiver hold-off
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    reconfigure(8'd0, 8'd3);
    rx_hold_req <= 1'b1;
    run_random(430);

    wait_results();
    repeat (4 * RESULT_LATENCY) @(posedge clk);
    if (mismatches == 0 && outputs_due == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/i2cm_pkg.sv
hdl/i2cm_step.sv
hdl/i2c_master_byte_engine.sv
test/i2cm_bus_checker.sv
test/testbench.sv
